// File: rtl/dpacc_pkg.sv
// shared types and constants for the packed int8/int4 dot-product accumulator
// no dependencies
package dpacc_pkg;

    localparam int LANES      = 4;
    localparam int BYTE_W     = 8;
    localparam int NIB_W      = 4;
    localparam int PROD_W     = 16;
    localparam int TERMS      = 2 * LANES;
    localparam int ITEM_SUM_W = PROD_W + $clog2(TERMS);
    localparam int WEIGHT_W   = LANES * BYTE_W;
    localparam int ACT_W      = TERMS * BYTE_W;
    localparam int IN_DATA_W  = WEIGHT_W + ACT_W;
    localparam int ACC_W      = 32;
    localparam int Q_DEPTH    = 4;
    localparam int Q_IDX_W    = $clog2(Q_DEPTH);

    localparam logic MODE_INT8 = 1'b0;
    localparam logic MODE_INT4 = 1'b1;

    typedef struct packed {
        logic signed [ITEM_SUM_W-1:0] sum;
        logic                         last;
    } t_item;

endpackage

// File: rtl/dpacc_front.sv
// front end: accepts input items, forms the lane products and the item sum
// depends on dpacc_pkg
module dpacc_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [dpacc_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            o_push,
    input  logic                            i_full,
    output dpacc_pkg::t_item                o_item
);
    import dpacc_pkg::*;

    logic                     r_mode;
    logic                     r_v1;
    logic                     r_v2;
    logic                     r_last1;
    logic signed [PROD_W-1:0] r_prod [TERMS];
    logic signed [PROD_W-1:0] n_prod [TERMS];
    t_item                    r_item;
    logic signed [ITEM_SUM_W-1:0] n_sum;
    logic                     adv2;
    logic                     adv1;
    logic                     accept;

    assign adv2          = !r_v2 || !i_full;
    assign adv1          = !r_v1 || adv2;
    assign s_axis_tready = adv1;
    assign accept        = s_axis_tvalid && adv1;
    assign o_push        = r_v2 && !i_full;
    assign o_item        = r_item;

    always_comb begin
        logic [BYTE_W-1:0]        w;
        logic signed [BYTE_W-1:0] w_lo;
        logic signed [BYTE_W-1:0] w_hi;
        logic signed [BYTE_W-1:0] a_lo;
        logic signed [BYTE_W-1:0] a_hi;
        for (int i = 0; i < LANES; i++) begin
            w    = s_axis_tdata[i*BYTE_W +: BYTE_W];
            a_lo = s_axis_tdata[WEIGHT_W + i*BYTE_W +: BYTE_W];
            a_hi = s_axis_tdata[WEIGHT_W + (i+LANES)*BYTE_W +: BYTE_W];
            w_hi = {{(BYTE_W-NIB_W){w[BYTE_W-1]}}, w[BYTE_W-1:NIB_W]};
            if (r_mode == MODE_INT4) begin
                w_lo = {{(BYTE_W-NIB_W){w[NIB_W-1]}}, w[NIB_W-1:0]};
                n_prod[i+LANES] = w_hi * a_hi;
            end else begin
                w_lo = w;
                n_prod[i+LANES] = '0;
            end
            n_prod[i] = w_lo * a_lo;
        end
    end

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < TERMS; k++) begin
            n_sum = n_sum + ITEM_SUM_W'(r_prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_INT8;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (adv1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod  <= n_prod;
            r_last1 <= s_axis_tlast;
        end
        if (adv2 && r_v1) begin
            r_item.sum  <= n_sum;
            r_item.last <= r_last1;
        end
    end

endmodule

// File: rtl/dpacc_queue.sv
// short item queue between the front end and the accumulator
// depends on dpacc_pkg
module dpacc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dpacc_pkg::t_item i_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output dpacc_pkg::t_item o_item
);
    import dpacc_pkg::*;

    t_item              r_mem [Q_DEPTH];
    logic [Q_IDX_W-1:0] r_wr;
    logic [Q_IDX_W-1:0] r_rd;
    logic [Q_IDX_W:0]   r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == (Q_IDX_W+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// File: rtl/dpacc_back.sv
// back end: row accumulator and registered result output
// depends on dpacc_pkg
module dpacc_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  dpacc_pkg::t_item            i_item,
    output logic                        o_pop,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [dpacc_pkg::ACC_W-1:0] m_axis_tdata
);
    import dpacc_pkg::*;

    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] r_out;
    logic             r_out_v;
    logic [ACC_W-1:0] n_acc;
    logic             out_free;

    assign out_free      = !r_out_v || m_axis_tready;
    assign o_pop         = !i_empty && (!i_item.last || out_free);
    assign n_acc         = r_acc + ACC_W'(i_item.sum);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (r_out_v && m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            if (o_pop) begin
                if (i_item.last) begin
                    r_acc   <= '0;
                    r_out_v <= 1'b1;
                end else begin
                    r_acc <= n_acc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            r_out <= n_acc;
        end
    end

endmodule

// File: rtl/int8_int4_dot_product_accumulator_core.sv
// top level of the packed int8/int4 dot-product row accumulator
// depends on dpacc_pkg, dpacc_front, dpacc_queue, dpacc_back
//
// usage
// - s_axis carries one item per handshake: four weight bytes and eight
//   signed activation bytes; s_axis_tlast marks the last item of a row
// - m_axis carries one row sum per row, 32-bit wrapping two's complement
// - i_cfg_we/i_cfg_wdata write weight_mode (0 int8, 1 packed int4 pairs)
//   while the block is idle
// - throughput: one item per cycle while no last item waits on a stalled m_axis; the two-stage
//   multiply/add front end and the single accumulator each take one item per cycle
// - path: the last item of a row passes the product registers, the item-sum register, the queue
//   and the output register before its row sum shows on m_axis
// - a four-entry queue parts the front end from the accumulator; when
//   m_axis stalls, non-last items keep draining into the accumulator and
//   s_axis_tready drops only once the queue and front end are full
// - reset clears the accumulator, the queue and the output, and sets
//   weight_mode to int8
module int8_int4_dot_product_accumulator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // weight_bytes [31:0], act_bytes [95:32]
    input  logic        s_axis_tlast,   // row_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // row_sum [31:0]
);
    import dpacc_pkg::*;

    t_item f_item;
    t_item q_item;
    logic  push;
    logic  full;
    logic  pop;
    logic  empty;

    dpacc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .o_push        (push),
        .i_full        (full),
        .o_item        (f_item)
    );

    dpacc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (q_item)
    );

    dpacc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_item        (q_item),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
